FILE: design/gpd_pkg.sv
// Shared constants and types for the pyramid downsampler.
`default_nettype none
package gpd_pkg;
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  localparam int QDEPTH = 4;
  localparam int ODEPTH = 8;
  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef logic [7:0] pix_t;
  typedef pix_t [4:0][4:0] win_t;

  // One classified job: a window snapshot plus slot selects for each output.
  typedef struct packed {
    win_t win;
    logic [1:0] nr;
    logic [1:0] nc;
    logic [1:0][4:0][2:0] rsel;
    logic [1:0][4:0][2:0] csel;
    logic [1:0][1:0] last;
  } job_t;

  function automatic logic [2:0] slot_of(input int m, input int base);
    int d;
    begin
      d = m - base;
      if (d < 0) d = 0;
      if (d > 4) d = 4;
      return 3'(d);
    end
  endfunction

  function automatic int mirror(input int x, input int n);
    int y;
    begin
      y = x;
      if (y < 0) y = -y - 1;
      if (y >= n) y = 2 * n - 1 - y;
      if (y < 0) y = 0;
      if (y >= n) y = n - 1;
      return y;
    end
  endfunction

  function automatic logic [3:0] tap(input int k);
    begin
      case (k)
        0, 4: return 4'd1;
        1, 3: return 4'd4;
        default: return 4'd6;
      endcase
    end
  endfunction
endpackage
`default_nettype wire

FILE: design/gpd_ram.sv
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module gpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic re,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/gpd_front.sv
// Front: line stores, 5x5 window, position counters and output classification.
`default_nettype none
module gpd_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic [7:0] pixel,
  input wire logic restart,
  input wire logic [gpd_pkg::WCFG_W-1:0] img_width,
  input wire logic [gpd_pkg::HCFG_W-1:0] img_height,
  output logic job_valid,
  output gpd_pkg::job_t job
);
  logic [gpd_pkg::COL_W-1:0] col;
  logic [gpd_pkg::ROW_W-1:0] row;
  logic [gpd_pkg::COL_W-1:0] col_next;
  logic [gpd_pkg::ROW_W-1:0] row_next;
  logic [gpd_pkg::COL_W:0] w;
  logic [gpd_pkg::ROW_W:0] h;
  // stage 1: memory read in flight
  logic s1;
  logic [7:0] s1_pix;
  logic [gpd_pkg::COL_W-1:0] s1_col;
  logic [gpd_pkg::ROW_W-1:0] s1_row;
  logic [3:0][7:0] rd;
  logic [3:0][7:0] fwd;
  logic [gpd_pkg::COL_W-1:0] fwd_col;
  logic fwd_ok;
  logic [3:0][7:0] colv;
  logic [3:0][7:0] wcol;
  gpd_pkg::win_t win;
  gpd_pkg::win_t win_next;
  gpd_pkg::job_t jn;
  logic jv;

  always_comb begin
    w = (img_width < 11'd2) ? 11'd2 :
        (img_width > 11'(gpd_pkg::MAX_WIDTH)) ? 11'(gpd_pkg::MAX_WIDTH) : img_width;
    h = (img_height < 13'd2) ? 13'd2 :
        (img_height > 13'(gpd_pkg::MAX_HEIGHT)) ? 13'(gpd_pkg::MAX_HEIGHT) : img_height;
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if ({1'b0, col} + 1'b1 >= w) begin
      col_next = '0;
      row_next = ({1'b0, row} + 1'b1 >= h) ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      col <= col_next;
      row <= row_next;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_ls
    gpd_ram #(.WIDTH(8), .DEPTH(gpd_pkg::MAX_WIDTH)) u_ram (
      .clk(clk), .we(s1), .waddr(s1_col), .wdata(wcol[k]),
      .re(push), .raddr(col), .rdata(rd[k]));
  end

  // column entering window: line stores shift up, new pixel at bottom
  always_comb begin
    for (int k = 0; k < 4; k++)
      colv[k] = (fwd_ok && fwd_col == s1_col) ? fwd[k] : rd[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      fwd_ok <= 1'b0;
    end else begin
      s1 <= push;
      if (s1) fwd_ok <= 1'b1;
      else if (push) fwd_ok <= 1'b0;
    end
    if (push) begin
      s1_pix <= pixel;
      s1_col <= col;
      s1_row <= row;
    end
    if (s1) begin
      fwd_col <= s1_col;
      for (int k = 0; k < 3; k++) fwd[k] <= colv[k + 1];
      fwd[3] <= s1_pix;
    end
  end

  // store writes the shifted column: line k gets window row k+1
  always_comb begin
    for (int k = 0; k < 3; k++) wcol[k] = colv[k + 1];
    wcol[3] = s1_pix;
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      for (int x = 0; x < 4; x++) win_next[k][x] = win[k][x + 1];
    end
    for (int k = 0; k < 4; k++) win_next[k][4] = colv[k];
    win_next[4][4] = s1_pix;
  end

  always_comb begin
    int r, c, wi, hi, ow, oh, nr, nc, t, b;
    r = int'(s1_row);
    c = int'(s1_col);
    wi = int'(w);
    hi = int'(h);
    ow = (wi + 1) >> 1;
    oh = (hi + 1) >> 1;
    jn = '0;
    jn.win = win_next;
    nr = 0;
    nc = 0;
    for (int k = 0; k < 2; k++) begin
      b = (r >> 1) - 1 + k;
      t = 2 * b + 2;
      if (t > hi - 1) t = hi - 1;
      if (b >= 0 && b < oh && t == r) begin
        for (int d = 0; d < 5; d++)
          jn.rsel[nr][d] = gpd_pkg::slot_of(gpd_pkg::mirror(2 * b - 2 + d, hi), r - 4);
        jn.last[nr][0] = (b == oh - 1);
        nr = nr + 1;
      end
    end
    for (int k = 0; k < 2; k++) begin
      b = (c >> 1) - 1 + k;
      t = 2 * b + 2;
      if (t > wi - 1) t = wi - 1;
      if (b >= 0 && b < ow && t == c) begin
        for (int d = 0; d < 5; d++)
          jn.csel[nc][d] = gpd_pkg::slot_of(gpd_pkg::mirror(2 * b - 2 + d, wi), c - 4);
        jn.last[nc][1] = (b == ow - 1);
        nc = nc + 1;
      end
    end
    jn.nr = 2'(nr);
    jn.nc = 2'(nc);
    jv = s1 && nr != 0 && nc != 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= jv;
      if (s1) win <= win_next;
    end
    if (jv) job <= jn;
  end
endmodule
`default_nettype wire

FILE: design/gpd_back.sv
// Back: expands a job into its outputs and computes the 25-tap sums.
`default_nettype none
module gpd_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic job_valid,
  input gpd_pkg::job_t job,
  output logic job_pop,
  input wire logic out_room,
  output logic res_valid,
  output logic [7:0] res_pixel,
  output logic res_last
);
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic a;
  logic b;
  logic fire;
  logic [4:0][11:0] rsum;
  logic [4:0][11:0] rsum_q;
  logic s_v;
  logic s_last;
  logic [15:0] tot;

  assign a = idx[1];
  assign b = idx[0];
  always_comb begin
    logic [1:0] nn;
    nn = (job.nc == 2'd2) ? 2'd1 : 2'd0;
    fire = job_valid && out_room;
    idx_next = idx;
    job_pop = 1'b0;
    if (fire) begin
      if (b == 1'b0 && job.nc == 2'd2) idx_next = {a, 1'b1};
      else if (a == 1'b0 && job.nr == 2'd2) idx_next = 2'b10;
      else begin
        idx_next = 2'b00;
        job_pop = 1'b1;
      end
    end
    if (nn == 2'd3) idx_next = 2'b00;
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= 2'b00;
    else idx <= idx_next;
  end

  // horizontal pass per window row
  always_comb begin
    for (int y = 0; y < 5; y++) begin
      rsum[y] = '0;
      for (int x = 0; x < 5; x++)
        rsum[y] = rsum[y] + 12'(gpd_pkg::tap(x)) *
                  12'(job.win[job.rsel[a][y]][job.csel[b][x]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s_v <= 1'b0;
    else s_v <= fire;
    if (fire) begin
      for (int y = 0; y < 5; y++) rsum_q[y] <= rsum[y];
      s_last <= job.last[a][0] && job.last[b][1];
    end
  end

  always_comb begin
    tot = 16'd128;
    for (int y = 0; y < 5; y++) tot = tot + 16'(gpd_pkg::tap(y)) * 16'(rsum_q[y]);
  end

  assign res_valid = s_v;
  assign res_pixel = tot[15:8];
  assign res_last = s_last;
endmodule
`default_nettype wire

FILE: design/gaussian_pyramid_downsample.sv
// Top level of the 5x5 Gaussian pyramid reduce.
//
// Accepts one pixel per clock in raster order and emits the (W+1)/2 x (H+1)/2
// level filtered by [1 4 6 4 1]^2/256 with mirrored borders. The front
// (line-store RAM read, window shift, classification) takes one pixel every
// cycle; a pixel may cause up to four outputs, which the back computes at one
// per cycle in two stages. Input stalls when the job queue backs up: when
// several multi-output pixels crowd it, or when results are not popped and
// the result queue fills. Writing a size register restarts the frame.
`default_nettype none
module gaussian_pyramid_downsample (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire logic [7:0] pixel,
  output logic empty,
  input wire logic pop,
  output logic [7:0] out_pixel,
  output logic frame_last,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [1:0] cfg_index,
  input wire logic [12:0] cfg_data
);
  logic [gpd_pkg::WCFG_W-1:0] img_width;
  logic [gpd_pkg::HCFG_W-1:0] img_height;
  logic cfg_we;
  logic acc;
  logic jv;
  gpd_pkg::job_t jin;
  gpd_pkg::job_t qh;
  gpd_pkg::job_t jq [gpd_pkg::QDEPTH];
  logic [1:0] qw, qr;
  logic [2:0] qn;
  logic qpop;
  logic rv;
  logic [7:0] rp;
  logic rl;
  logic [8:0] oq [gpd_pkg::ODEPTH];
  logic [2:0] ow, orr;
  logic [3:0] on;
  logic [3:0] inflight;
  logic opop;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && (cfg_index == gpd_pkg::REG_WIDTH ||
                                cfg_index == gpd_pkg::REG_HEIGHT);
  always_ff @(posedge clk) begin
    if (rst) begin
      img_width <= 11'd640;
      img_height <= 13'd480;
    end else if (cfg_valid) begin
      if (cfg_index == gpd_pkg::REG_WIDTH) img_width <= cfg_data[10:0];
      if (cfg_index == gpd_pkg::REG_HEIGHT) img_height <= cfg_data;
    end
  end

  // job queue must absorb two jobs in flight in the front
  assign full = (qn > 3'd1);
  assign acc = push && !full;

  gpd_front u_front (
    .clk(clk), .rst(rst), .push(acc), .pixel(pixel), .restart(cfg_we),
    .img_width(img_width), .img_height(img_height),
    .job_valid(jv), .job(jin));

  assign qh = jq[qr];
  always_ff @(posedge clk) begin
    if (rst) begin
      qw <= '0;
      qr <= '0;
      qn <= '0;
    end else begin
      if (jv) qw <= qw + 1'b1;
      if (qpop) qr <= qr + 1'b1;
      qn <= qn + 3'(jv) - 3'(qpop);
    end
    if (jv) jq[qw] <= jin;
  end

  // output room counts results in flight in the back's second stage
  assign inflight = on + 4'(rv);
  gpd_back u_back (
    .clk(clk), .rst(rst), .job_valid(qn != 3'd0), .job(qh), .job_pop(qpop),
    .out_room(inflight < 4'(gpd_pkg::ODEPTH - 1)),
    .res_valid(rv), .res_pixel(rp), .res_last(rl));

  assign empty = (on == 4'd0);
  assign opop = pop && !empty;
  assign out_pixel = oq[orr][7:0];
  assign frame_last = oq[orr][8];
  always_ff @(posedge clk) begin
    if (rst) begin
      ow <= '0;
      orr <= '0;
      on <= '0;
    end else begin
      if (rv) ow <= ow + 1'b1;
      if (opop) orr <= orr + 1'b1;
      on <= on + 4'(rv) - 4'(opop);
    end
    if (rv) oq[ow] <= {rl, rp};
  end
endmodule
`default_nettype wire

FILE: design/gpd_checker.sv
// Port-level checks for the pyramid downsampler, bound to the top level.
`default_nettype none
module gpd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire logic frame_last,
  input wire logic cfg_ready
);
  a_empty_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("results present after reset");
  a_full_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config not ready");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result lost");
  a_last_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown(frame_last))
    else $error("frame_last unknown on a waiting result");
endmodule

bind gaussian_pyramid_downsample gpd_checker u_chk (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .frame_last(frame_last), .cfg_ready(cfg_ready));
`default_nettype wire

FILE: verif/gaussian_pyramid_downsample_tb.sv
// Testbench for the 5x5 Gaussian pyramid reduce: random frames checked against a predictor.
module gaussian_pyramid_downsample_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [7:0] pix;
    logic last;
  } level_pix_t;

  class pyr_scoreboard;
    logic [7:0] lines[4][gpd_pkg::MAX_WIDTH];
    logic [7:0] win[5][5];
    int col, row, w_reg, h_reg, errors;
    level_pix_t pending[$];

    function new();
      foreach (lines[a, b]) lines[a][b] = '0;
      foreach (win[a, b]) win[a][b] = '0;
      col = 0; row = 0; errors = 0;
      w_reg = 640; h_reg = 480;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] d);
      if (idx == gpd_pkg::REG_WIDTH) w_reg = d[10:0];
      else if (idx == gpd_pkg::REG_HEIGHT) h_reg = d;
      else return;
      col = 0; row = 0;
    endfunction

    function int reflect(int x, int n);
      if (x < 0) x = -x - 1;
      if (x >= n) x = 2 * n - 1 - x;
      if (x < 0) x = 0;
      if (x >= n) x = n - 1;
      return x;
    endfunction

    function int clip(int i);
      return (i < 0) ? 0 : (i > 4) ? 4 : i;
    endfunction

    function int kern(int k);
      return (k == 0 || k == 4) ? 1 : (k == 2) ? 6 : 4;
    endfunction

    function logic [7:0] filt(int i, int j, int r, int c, int w, int h);
      int sum, ry, cx;
      sum = 0;
      for (int dy = 0; dy < 5; dy++) begin
        ry = clip(reflect(2 * i - 2 + dy, h) - (r - 4));
        for (int dx = 0; dx < 5; dx++) begin
          cx = clip(reflect(2 * j - 2 + dx, w) - (c - 4));
          sum += kern(dy) * kern(dx) * win[ry][cx];
        end
      end
      return 8'((sum + 128) >> 8);
    endfunction

    function void note_pixel(logic [7:0] p);
      int w, h, ow, oh, r, c, t, nr, nc;
      int rows[2], cols[2];
      level_pix_t e;
      w = (w_reg < 2) ? 2 : (w_reg > gpd_pkg::MAX_WIDTH) ? gpd_pkg::MAX_WIDTH : w_reg;
      h = (h_reg < 2) ? 2 : (h_reg > gpd_pkg::MAX_HEIGHT) ? gpd_pkg::MAX_HEIGHT : h_reg;
      ow = (w + 1) / 2; oh = (h + 1) / 2;
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      r = row; c = col;
      for (int k = 0; k < 5; k++)
        for (int m = 0; m < 4; m++) win[k][m] = win[k][m + 1];
      for (int k = 0; k < 4; k++) win[k][4] = lines[k][c];
      win[4][4] = p;
      for (int k = 0; k < 4; k++) lines[k][c] = win[k + 1][4];
      nr = 0; nc = 0;
      for (int k = r / 2 - 1; k <= r / 2; k++) begin
        t = (2 * k + 2 > h - 1) ? h - 1 : 2 * k + 2;
        if (k >= 0 && k < oh && t == r) begin rows[nr] = k; nr++; end
      end
      for (int k = c / 2 - 1; k <= c / 2; k++) begin
        t = (2 * k + 2 > w - 1) ? w - 1 : 2 * k + 2;
        if (k >= 0 && k < ow && t == c) begin cols[nc] = k; nc++; end
      end
      for (int a = 0; a < nr; a++)
        for (int b = 0; b < nc; b++) begin
          e.pix = filt(rows[a], cols[b], r, c, w, h);
          e.last = (rows[a] == oh - 1 && cols[b] == ow - 1);
          pending.push_back(e);
        end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void report(string what, int got, int want);
      errors++;
      if (errors <= 30) $display("mismatch: %s got %0d expected %0d", what, got, want);
    endfunction

    function void check(logic [7:0] op, logic fl);
      level_pix_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction, out_pixel", op, -1);
        return;
      end
      e = pending.pop_front();
      if (op !== e.pix) report("out_pixel", op, e.pix);
      if (fl !== e.last) report("frame_last", fl, e.last);
    endfunction
  endclass

  logic clk, rst, push, full, empty, pop, frame_last, cfg_valid, cfg_ready;
  logic [7:0] pixel, out_pixel;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;
  int send_idle, recv_idle, hold_req, hold_cnt, quiet_cnt;
  pyr_scoreboard sb;

  gaussian_pyramid_downsample u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel(pixel),
    .empty(empty), .pop(pop), .out_pixel(out_pixel), .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random pop, with long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
      hold_cnt = 0;
    end else if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
      pop <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check(out_pixel, frame_last);
      if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready)) quiet_cnt = 0;
      else quiet_cnt++;
      if (quiet_cnt >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [7:0] p);
    int gap;
    if ($urandom_range(99) < send_idle) begin
      gap = $urandom_range(4, 1);
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    pixel <= p;
    do @(posedge clk); while (full);
    sb.note_pixel(p);
  endtask

  task automatic drain();
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [12:0] d);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, d);
  endtask

  function automatic logic [7:0] rand_pix();
    int k;
    k = $urandom_range(9);
    return (k == 0) ? 8'd0 : (k == 1) ? 8'hff : 8'($urandom);
  endfunction

  task automatic send_frame(int w, int h, int n);
    write_cfg(gpd_pkg::REG_WIDTH, 13'(w));
    write_cfg(gpd_pkg::REG_HEIGHT, 13'(h));
    for (int i = 0; i < n; i++) send_pixel(rand_pix());
  endtask

  initial begin
    int sent, w, h;
    sb = new();
    rst <= 1; push <= 0; pixel <= 0; cfg_valid <= 0; cfg_index <= 0; cfg_data <= 0;
    send_idle = 0; recv_idle = 0; hold_req = 0; quiet_cnt = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // reset-size frame start, spare writes, then the smallest frames with flat extremes
    for (int i = 0; i < 10; i++) send_pixel(rand_pix());
    write_cfg(REG_SPARE_A, 13'h1fff);
    write_cfg(REG_SPARE_B, 13'd5);
    write_cfg(gpd_pkg::REG_WIDTH, 13'd2);
    write_cfg(gpd_pkg::REG_HEIGHT, 13'd2);
    repeat (4) send_pixel(8'hff);
    repeat (4) send_pixel(8'h00);
    send_frame(3, 3, 9);
    send_frame(1, 1, 4);
    send_frame(5, 4, 20);
    // largest sizes and out-of-range values, cut short
    send_frame(2047, 2, 16);
    send_frame(0, 8191, 16);
    send_frame(2, 4096, 16);
    send_frame(1024, 4096, 16);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 32 : (mode == 1) ? 54 : 0;
      recv_idle = (mode == 0) ? 54 : (mode == 1) ? 32 : 0;
      sent = 0;
      if (mode == 0) begin
        write_cfg(gpd_pkg::REG_WIDTH, 13'd5);
        write_cfg(gpd_pkg::REG_HEIGHT, 13'd5);
        hold_req = 300;
        for (int i = 0; i < 25; i++) send_pixel(rand_pix());
        sent = 25;
      end
      while (sent < 60) begin
        w = $urandom_range(9, 2);
        h = $urandom_range(9, 2);
        // occasionally a cut-off frame
        send_frame(w, h, ($urandom_range(9) == 0) ? $urandom_range(w * h) : w * h);
        sent += w * h;
      end
    end

    drain();
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
